// File: sv/id3fp_pkg.sv
`default_nettype none
// ============================================================================
// id3fp_pkg
// Shared types, codes and helpers of the ID3v2 first-picture extractor.
// ============================================================================
package id3fp_pkg;

   // Default width of tag, frame and position counters
   localparam int SIZE_BITS_DEFAULT = 29;

   // Header constants
   localparam logic [7:0]  MAGIC_I   = 8'h49;
   localparam logic [7:0]  MAGIC_D   = 8'h44;
   localparam logic [7:0]  MAGIC_3   = 8'h33;
   localparam logic [7:0]  VER_3     = 8'h03;
   localparam logic [7:0]  VER_4     = 8'h04;
   localparam int          UNSYNC_BIT = 7;
   localparam int          EXTHDR_BIT = 6;
   localparam logic [31:0] ID_APIC   = 32'h41504943;
   localparam logic [7:0]  ENC_UTF16 = 8'h01;
   localparam logic [7:0]  ENC_UTF16BE = 8'h02;

   // Parse phases, one-hot
   typedef enum logic [10:0] {
      PH_HDR    = 11'b000_0000_0001,
      PH_EXTSZ  = 11'b000_0000_0010,
      PH_FHDR   = 11'b000_0000_0100,
      PH_SKIP   = 11'b000_0000_1000,
      PH_ENC    = 11'b000_0001_0000,
      PH_MIME   = 11'b000_0010_0000,
      PH_TYPE   = 11'b000_0100_0000,
      PH_DESC_A = 11'b000_1000_0000,
      PH_DESC_B = 11'b001_0000_0000,
      PH_DATA   = 11'b010_0000_0000,
      PH_DONE   = 11'b100_0000_0000
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_FINAL = 2'd1,
      ST_NOPIC = 2'd2,
      ST_TRUNC = 2'd3
   } status_type;

   // Result word from the parser to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] picture_byte;
      status_type status;
      logic       last;
   } result_type;

   // Synchsafe size: 7-bit groups, raw bytes ORed without masking bit 7
   function automatic logic [28:0] synchsafe(input logic [31:0] v);
      synchsafe = {v[31:24], 21'b0} | {7'b0, v[23:16], 14'b0} |
                  {14'b0, v[15:8], 7'b0} | {21'b0, v[7:0]};
   endfunction

endpackage
`default_nettype wire

// File: sv/id3fp_if.sv
`default_nettype none
// ============================================================================
// id3fp_if
// Valid/ready channels of the extractor: file bytes in, picture words out.
// ============================================================================
interface id3fp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, file_byte, end_of_file, input ready);
   modport sink   (input valid, file_byte, end_of_file, output ready);
endinterface

interface id3fp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] picture_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, picture_byte, status, last, input ready);
   modport sink   (input valid, picture_byte, status, last, output ready);
endinterface
`default_nettype wire

// File: sv/id3fp_parser.sv
`default_nettype none
// ============================================================================
// id3fp_parser
// Tag and frame parse state; one byte per take, result word combinational.
// ============================================================================
module id3fp_parser #(
   parameter int SIZE_BITS = id3fp_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic [7:0]             file_byte,
   input  wire logic                   end_of_file,
   output id3fp_pkg::result_type       result
);

   localparam logic [32:0] SIZE_MASK = (33'd1 << SIZE_BITS) - 33'd1;

   // State
   id3fp_pkg::phase_type   phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   pos_ff, pos_in;
   logic [SIZE_BITS-1:0]   tag_len_ff, tag_len_in;
   logic                   ver3_ff, ver3_in;
   logic                   ext_ff, ext_in;
   logic [31:0]            asm_ff, asm_in;
   logic [31:0]            fid_ff, fid_in;
   logic [SIZE_BITS-1:0]   flen_ff, flen_in;
   logic [15:0]            flags_ff, flags_in;
   logic [SIZE_BITS-1:0]   foff_ff, foff_in;
   logic                   wide_ff, wide_in;
   logic                   pair_ff, pair_in;

   // Shared arithmetic
   logic [SIZE_BITS-1:0]   pos_inc;
   logic [SIZE_BITS-1:0]   foff_inc;
   logic [31:0]            asm_shift;
   logic [15:0]            flags_shift;
   logic [32:0]            hdr_size;
   logic                   hdr_no_room;
   logic                   walk_no_room;
   logic [32:0]            ext_raw;
   logic [32:0]            ext_target;
   logic                   ext_over;
   logic [32:0]            frm_size;
   logic                   frm_over;
   logic                   frame_end;
   logic                   was_done;
   id3fp_pkg::result_type  res;

   assign pos_inc     = pos_ff + SIZE_BITS'(1);
   assign foff_inc    = foff_ff + SIZE_BITS'(1);
   assign asm_shift   = {asm_ff[23:0], file_byte};
   assign flags_shift = {flags_ff[7:0], file_byte};

   // Tag size from header; a frame walk needs room for one frame header
   assign hdr_size    = 33'(id3fp_pkg::synchsafe(asm_shift));
   assign hdr_no_room = hdr_size < 33'd10;
   assign walk_no_room = (({1'b0, pos_inc}) + (SIZE_BITS+1)'(10)) > {1'b0, tag_len_ff};

   // Extended header skip length, at least the 4 size bytes
   assign ext_raw    = ver3_ff ? ({1'b0, asm_shift} + 33'd4)
                               : 33'(id3fp_pkg::synchsafe(asm_shift));
   assign ext_target = (ext_raw < 33'd4) ? 33'd4 : ext_raw;
   assign ext_over   = ({1'b0, ext_target} + 34'd10) > 34'(tag_len_ff);

   // Frame size check against tag end
   assign frm_size = ver3_ff ? {1'b0, asm_ff} : 33'(id3fp_pkg::synchsafe(asm_ff));
   assign frm_over = (frm_size == 33'd0) ||
                     ((34'(pos_inc) + {1'b0, frm_size}) > 34'(tag_len_ff));

   assign frame_end = foff_inc >= flen_ff;
   assign was_done  = (phase_ff == id3fp_pkg::PH_DONE);

   // Next state and result
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      tag_len_in = tag_len_ff;
      ver3_in    = ver3_ff;
      ext_in     = ext_ff;
      asm_in     = asm_ff;
      fid_in     = fid_ff;
      flen_in    = flen_ff;
      flags_in   = flags_ff;
      foff_in    = foff_ff;
      wide_in    = wide_ff;
      pair_in    = pair_ff;
      res.valid        = 1'b0;
      res.picture_byte = 8'd0;
      res.status       = id3fp_pkg::ST_NOPIC;
      res.last         = 1'b0;

      unique case (phase_ff)
         id3fp_pkg::PH_HDR: begin
            pos_in = pos_inc;
            if (pos_ff >= SIZE_BITS'(6)) begin
               asm_in = asm_shift;
            end
            if ((pos_ff == SIZE_BITS'(0) && file_byte != id3fp_pkg::MAGIC_I) ||
                (pos_ff == SIZE_BITS'(1) && file_byte != id3fp_pkg::MAGIC_D) ||
                (pos_ff == SIZE_BITS'(2) && file_byte != id3fp_pkg::MAGIC_3) ||
                (pos_ff == SIZE_BITS'(3) && file_byte != id3fp_pkg::VER_3 &&
                 file_byte != id3fp_pkg::VER_4) ||
                (pos_ff == SIZE_BITS'(5) && file_byte[id3fp_pkg::UNSYNC_BIT])) begin
               phase_in  = id3fp_pkg::PH_DONE;
               res.valid = 1'b1;
            end else if (pos_ff == SIZE_BITS'(3)) begin
               ver3_in = (file_byte == id3fp_pkg::VER_3);
            end else if (pos_ff == SIZE_BITS'(5)) begin
               ext_in = file_byte[id3fp_pkg::EXTHDR_BIT];
            end else if (pos_ff == SIZE_BITS'(9)) begin
               pos_in     = '0;
               tag_len_in = hdr_size[SIZE_BITS-1:0];
               foff_in    = '0;
               if (hdr_size > SIZE_MASK) begin
                  phase_in  = id3fp_pkg::PH_DONE;
                  res.valid = 1'b1;
               end else if (ext_ff) begin
                  if (hdr_size < 33'd4) begin
                     phase_in  = id3fp_pkg::PH_DONE;
                     res.valid = 1'b1;
                  end else begin
                     phase_in = id3fp_pkg::PH_EXTSZ;
                  end
               end else if (hdr_no_room) begin
                  phase_in  = id3fp_pkg::PH_DONE;
                  res.valid = 1'b1;
               end else begin
                  phase_in = id3fp_pkg::PH_FHDR;
               end
            end
         end

         id3fp_pkg::PH_EXTSZ: begin
            pos_in  = pos_inc;
            asm_in  = asm_shift;
            foff_in = foff_inc;
            if (foff_ff == SIZE_BITS'(3)) begin
               foff_in = '0;
               if (ext_over) begin
                  phase_in  = id3fp_pkg::PH_DONE;
                  res.valid = 1'b1;
               end else if (ext_target == 33'd4) begin
                  if (walk_no_room) begin
                     phase_in  = id3fp_pkg::PH_DONE;
                     res.valid = 1'b1;
                  end else begin
                     phase_in = id3fp_pkg::PH_FHDR;
                  end
               end else begin
                  flen_in  = SIZE_BITS'(ext_target - 33'd4);
                  phase_in = id3fp_pkg::PH_SKIP;
               end
            end
         end

         id3fp_pkg::PH_FHDR: begin
            pos_in  = pos_inc;
            foff_in = foff_inc;
            if (foff_ff == SIZE_BITS'(0) && file_byte == 8'd0) begin
               // padding reached
               phase_in  = id3fp_pkg::PH_DONE;
               res.valid = 1'b1;
            end else begin
               if (foff_ff < SIZE_BITS'(4)) begin
                  fid_in = {fid_ff[23:0], file_byte};
               end else if (foff_ff < SIZE_BITS'(8)) begin
                  asm_in = asm_shift;
               end else begin
                  flags_in = flags_shift;
               end
               if (foff_ff == SIZE_BITS'(9)) begin
                  foff_in = '0;
                  if (frm_over) begin
                     phase_in  = id3fp_pkg::PH_DONE;
                     res.valid = 1'b1;
                  end else begin
                     flen_in = frm_size[SIZE_BITS-1:0];
                     if (fid_ff == id3fp_pkg::ID_APIC && flags_shift == 16'd0 &&
                         frm_size >= 33'd2) begin
                        phase_in = id3fp_pkg::PH_ENC;
                     end else begin
                        phase_in = id3fp_pkg::PH_SKIP;
                     end
                  end
               end
            end
         end

         id3fp_pkg::PH_DATA: begin
            pos_in           = pos_inc;
            foff_in          = foff_inc;
            res.valid        = 1'b1;
            res.picture_byte = file_byte;
            if (frame_end) begin
               phase_in   = id3fp_pkg::PH_DONE;
               res.status = id3fp_pkg::ST_FINAL;
            end else begin
               res.status = id3fp_pkg::ST_DATA;
            end
         end

         id3fp_pkg::PH_SKIP, id3fp_pkg::PH_ENC, id3fp_pkg::PH_MIME,
         id3fp_pkg::PH_TYPE, id3fp_pkg::PH_DESC_A, id3fp_pkg::PH_DESC_B: begin
            pos_in  = pos_inc;
            foff_in = foff_inc;
            case (phase_ff)
               id3fp_pkg::PH_ENC: begin
                  wide_in  = (file_byte == id3fp_pkg::ENC_UTF16) ||
                             (file_byte == id3fp_pkg::ENC_UTF16BE);
                  phase_in = id3fp_pkg::PH_MIME;
               end
               id3fp_pkg::PH_MIME: begin
                  if (file_byte == 8'd0) begin
                     phase_in = id3fp_pkg::PH_TYPE;
                  end
               end
               id3fp_pkg::PH_TYPE: begin
                  pair_in  = 1'b0;
                  phase_in = id3fp_pkg::PH_DESC_A;
               end
               id3fp_pkg::PH_DESC_A: begin
                  if (wide_ff) begin
                     pair_in  = (file_byte == 8'd0);
                     phase_in = id3fp_pkg::PH_DESC_B;
                  end else if (file_byte == 8'd0) begin
                     phase_in = id3fp_pkg::PH_DATA;
                  end
               end
               id3fp_pkg::PH_DESC_B: begin
                  phase_in = (pair_ff && file_byte == 8'd0) ? id3fp_pkg::PH_DATA
                                                            : id3fp_pkg::PH_DESC_A;
               end
               default: begin
               end
            endcase
            // frame exhausted: move to the next frame header
            if (frame_end) begin
               foff_in = '0;
               if (walk_no_room) begin
                  phase_in  = id3fp_pkg::PH_DONE;
                  res.valid = 1'b1;
               end else begin
                  phase_in = id3fp_pkg::PH_FHDR;
               end
            end
         end

         default: begin
         end
      endcase

      // End of file: truncated unless the file was already concluded or this byte concluded it
      if (end_of_file && !was_done &&
          (!res.valid || res.status == id3fp_pkg::ST_DATA)) begin
         res.valid        = 1'b1;
         res.status       = id3fp_pkg::ST_TRUNC;
         res.picture_byte = 8'd0;
      end
      res.last = (res.status != id3fp_pkg::ST_DATA);
   end

   assign result = res;

   // State registers; end of file returns to the reset state
   always_ff @(posedge clock) begin
      if (reset || (take && end_of_file)) begin
         phase_ff   <= id3fp_pkg::PH_HDR;
         pos_ff     <= '0;
         tag_len_ff <= '0;
         ver3_ff    <= 1'b0;
         ext_ff     <= 1'b0;
         asm_ff     <= '0;
         fid_ff     <= '0;
         flen_ff    <= '0;
         flags_ff   <= '0;
         foff_ff    <= '0;
         wide_ff    <= 1'b0;
         pair_ff    <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         tag_len_ff <= tag_len_in;
         ver3_ff    <= ver3_in;
         ext_ff     <= ext_in;
         asm_ff     <= asm_in;
         fid_ff     <= fid_in;
         flen_ff    <= flen_in;
         flags_ff   <= flags_in;
         foff_ff    <= foff_in;
         wide_ff    <= wide_in;
         pair_ff    <= pair_in;
      end
   end

`ifndef NO_ASSERTIONS
   // End of file always restarts at the tag header
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      take && end_of_file |=> phase_ff == id3fp_pkg::PH_HDR)
      else $error("parser did not restart after end of file");

   // A final result leaves the parser concluded or restarted
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      take && res.valid && res.last |=>
         (phase_ff == id3fp_pkg::PH_DONE || phase_ff == id3fp_pkg::PH_HDR))
      else $error("parser kept parsing after a final result");

   // A concluded parser produces nothing until end of file
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      was_done && !end_of_file |-> !res.valid)
      else $error("result produced after conclusion");
`endif

endmodule
`default_nettype wire

// File: sv/id3v2_first_picture_extractor_core.sv
`default_nettype none
// ============================================================================
// id3v2_first_picture_extractor_core
// Streams the picture bytes of the first plain APIC frame of an ID3v2 tag.
// ============================================================================
// One file byte is taken per cycle, back to back, unless the result port stalls;
// the parse logic is combinational and each result word is captured in an output
// register. The input stays ready while that register is empty or is being
// drained in the same cycle, so a stalled result port holds the input off.
// Words with status 0 carry picture bytes, status 1 the final one; status 2
// (no picture) and 3 (file ended early) end a file. After a word with last
// set, bytes give no word until the end_of_file byte, which rearms the block.
module id3v2_first_picture_extractor_core #(
   parameter int SIZE_BITS = id3fp_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   id3fp_req_if.sink  req_if,
   id3fp_rsp_if.source rsp_if
);

   id3fp_pkg::result_type result;
   logic                  take;

   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff;
   logic [1:0]            out_status_ff;
   logic                  out_last_ff;

   // Input handshake
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;

   id3fp_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .file_byte   (req_if.file_byte),
      .end_of_file (req_if.end_of_file),
      .result      (result)
   );

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = result.valid;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff   <= result.picture_byte;
         out_status_ff <= result.status;
         out_last_ff   <= result.last;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.picture_byte = out_byte_ff;
   assign rsp_if.status       = out_status_ff;
   assign rsp_if.last         = out_last_ff;

`ifndef NO_ASSERTIONS
   // A held result word blocks new bytes
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("input accepted while result word stalled");

   // Last marks every word but a plain picture byte
   a_last_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |->
         (rsp_if.last == (rsp_if.status != id3fp_pkg::ST_DATA)))
      else $error("last flag disagrees with status");

   // No-picture and truncation words carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status == id3fp_pkg::ST_NOPIC ||
                       rsp_if.status == id3fp_pkg::ST_TRUNC) |->
         rsp_if.picture_byte == 8'd0)
      else $error("status word with nonzero picture byte");
`endif

endmodule
`default_nettype wire

// File: sim/id3fp_checker.sv
`default_nettype none
// ============================================================================
// id3fp_checker
// Scoreboard for the ID3v2 first-picture extractor.
// ============================================================================
// Watches both channels of the block. Each file byte taken on the input
// channel is run through a byte-level model of the tag parser. The words
// that the model produces are queued and compared, in order and field by
// field, with the words taken on the result channel.
module id3fp_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   id3fp_req_if        req,
   id3fp_rsp_if        rsp,
   output int unsigned error_count,
   output int unsigned words_pending,
   output int unsigned bytes_parsed
);

   localparam int SIZE_BITS = id3fp_pkg::SIZE_BITS_DEFAULT;
   localparam longint unsigned SIZE_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;

   typedef struct packed {
      logic [7:0]            picture_byte;
      id3fp_pkg::status_type status;
      logic                  last;
   } picture_word_type;

   picture_word_type picture_words[$];

   // Parser model state
   id3fp_pkg::phase_type stage;
   logic [SIZE_BITS-1:0] pos;
   logic [SIZE_BITS-1:0] tag_len;
   logic                 ver3;
   logic                 ext_hdr;
   logic [31:0]          acc;
   logic [31:0]          frame_id;
   logic [SIZE_BITS-1:0] frame_len;
   logic [15:0]          frame_flags;
   logic [SIZE_BITS-1:0] frame_off;
   logic                 wide_desc;
   logic                 zero_half;

   // Word produced by the byte being modeled
   logic                 word_due;
   picture_word_type     due_word;

   int unsigned faults;
   int unsigned words_seen;
   int unsigned parsed;

   // 7-bit groups of a size field, raw bytes ORed with no masking
   function automatic logic [31:0] unpack_size7(input logic [31:0] v);
      return ({24'h0, v[31:24]} << 21) | ({24'h0, v[23:16]} << 14) |
             ({24'h0, v[15:8]} << 7) | {24'h0, v[7:0]};
   endfunction

   function automatic void clear_model();
      stage       = id3fp_pkg::PH_HDR;
      pos         = '0;
      tag_len     = '0;
      ver3        = 1'b0;
      ext_hdr     = 1'b0;
      acc         = '0;
      frame_id    = '0;
      frame_len   = '0;
      frame_flags = '0;
      frame_off   = '0;
      wide_desc   = 1'b0;
      zero_half   = 1'b0;
   endfunction

   function automatic void conclude(input id3fp_pkg::status_type st);
      stage                 = id3fp_pkg::PH_DONE;
      word_due              = 1'b1;
      due_word.status       = st;
      due_word.picture_byte = 8'h00;
   endfunction

   // Go to the next frame header if one still fits in the tag
   function automatic void enter_frames();
      if (64'(pos) + 64'd10 > 64'(tag_len)) begin
         conclude(id3fp_pkg::ST_NOPIC);
      end else begin
         stage     = id3fp_pkg::PH_FHDR;
         frame_off = '0;
      end
   endfunction

   function automatic void header_byte(input logic [7:0] b);
      logic [SIZE_BITS-1:0] idx;
      logic [31:0]          sz;
      idx = pos;
      pos = pos + 1'b1;
      if ((idx == 0 && b != id3fp_pkg::MAGIC_I) || (idx == 1 && b != id3fp_pkg::MAGIC_D) ||
          (idx == 2 && b != id3fp_pkg::MAGIC_3)) begin
         conclude(id3fp_pkg::ST_NOPIC);
         return;
      end
      if (idx == 3) begin
         if (b != id3fp_pkg::VER_3 && b != id3fp_pkg::VER_4) begin
            conclude(id3fp_pkg::ST_NOPIC);
            return;
         end
         ver3 = (b == id3fp_pkg::VER_3);
      end
      if (idx == 5) begin
         if (b[id3fp_pkg::UNSYNC_BIT]) begin
            conclude(id3fp_pkg::ST_NOPIC);
            return;
         end
         ext_hdr = b[id3fp_pkg::EXTHDR_BIT];
      end
      if (idx >= 6) acc = {acc[23:0], b};
      if (idx == 9) begin
         sz  = unpack_size7(acc);
         pos = '0;
         if (64'(sz) > SIZE_LIMIT) begin
            conclude(id3fp_pkg::ST_NOPIC);
            return;
         end
         tag_len = sz[SIZE_BITS-1:0];
         if (ext_hdr) begin
            if (tag_len < 4) begin
               conclude(id3fp_pkg::ST_NOPIC);
               return;
            end
            stage     = id3fp_pkg::PH_EXTSZ;
            frame_off = '0;
         end else begin
            enter_frames();
         end
      end
   endfunction

   // Extended header size; v3 excludes the size field itself, v4 includes it
   function automatic void ext_byte(input logic [7:0] b);
      longint unsigned span;
      acc       = {acc[23:0], b};
      frame_off = frame_off + 1'b1;
      if (frame_off < 4) return;
      span = ver3 ? 64'(acc) + 64'd4 : 64'(unpack_size7(acc));
      if (span < 64'd4) span = 64'd4;
      if (span + 64'd10 > 64'(tag_len)) begin
         conclude(id3fp_pkg::ST_NOPIC);
         return;
      end
      if (span == 64'd4) begin
         enter_frames();
         return;
      end
      frame_len = SIZE_BITS'(span - 64'd4);
      frame_off = '0;
      stage     = id3fp_pkg::PH_SKIP;
   endfunction

   function automatic void frame_header_byte(input logic [7:0] b);
      logic [SIZE_BITS-1:0] idx;
      logic [31:0]          sz;
      idx       = frame_off;
      frame_off = frame_off + 1'b1;
      // a zero first id byte is padding
      if (idx == 0 && b == 8'h00) begin
         conclude(id3fp_pkg::ST_NOPIC);
         return;
      end
      if (idx < 4) frame_id = {frame_id[23:0], b};
      else if (idx < 8) acc = {acc[23:0], b};
      else frame_flags = {frame_flags[7:0], b};
      if (idx != 9) return;
      sz = ver3 ? acc : unpack_size7(acc);
      if (sz == 0 || 64'(pos) + 64'(sz) > 64'(tag_len)) begin
         conclude(id3fp_pkg::ST_NOPIC);
         return;
      end
      frame_len = sz[SIZE_BITS-1:0];
      frame_off = '0;
      if (frame_id == id3fp_pkg::ID_APIC && frame_flags == 16'h0000 && sz >= 2)
         stage = id3fp_pkg::PH_ENC;
      else stage = id3fp_pkg::PH_SKIP;
   endfunction

   function automatic void frame_body_byte(input logic [7:0] b);
      logic frame_end;
      frame_off = frame_off + 1'b1;
      frame_end = (frame_off >= frame_len);
      case (stage)
         id3fp_pkg::PH_ENC: begin
            wide_desc = (b == id3fp_pkg::ENC_UTF16 || b == id3fp_pkg::ENC_UTF16BE);
            stage     = id3fp_pkg::PH_MIME;
         end
         id3fp_pkg::PH_MIME: begin
            if (b == 8'h00) stage = id3fp_pkg::PH_TYPE;
         end
         id3fp_pkg::PH_TYPE: begin
            zero_half = 1'b0;
            stage     = id3fp_pkg::PH_DESC_A;
         end
         id3fp_pkg::PH_DESC_A: begin
            if (wide_desc) begin
               zero_half = (b == 8'h00);
               stage     = id3fp_pkg::PH_DESC_B;
            end else if (b == 8'h00) begin
               stage = id3fp_pkg::PH_DATA;
            end
         end
         id3fp_pkg::PH_DESC_B: begin
            stage = (zero_half && b == 8'h00) ? id3fp_pkg::PH_DATA : id3fp_pkg::PH_DESC_A;
         end
         id3fp_pkg::PH_DATA: begin
            if (frame_end) begin
               conclude(id3fp_pkg::ST_FINAL);
            end else begin
               word_due        = 1'b1;
               due_word.status = id3fp_pkg::ST_DATA;
            end
            due_word.picture_byte = b;
            return;
         end
         default: ;
      endcase
      if (frame_end) enter_frames();
   endfunction

   // One accepted file byte: advance the model, queue the word it causes
   function automatic void predict_byte(input logic [7:0] b, input logic eof);
      logic was_done;
      was_done = (stage == id3fp_pkg::PH_DONE);
      word_due = 1'b0;
      due_word = '0;
      parsed++;
      if (!was_done) begin
         if (stage == id3fp_pkg::PH_HDR) begin
            header_byte(b);
         end else begin
            pos = pos + 1'b1;
            if (stage == id3fp_pkg::PH_EXTSZ) ext_byte(b);
            else if (stage == id3fp_pkg::PH_FHDR) frame_header_byte(b);
            else frame_body_byte(b);
         end
      end
      // file ends with no conclusion yet: truncated, a pending data byte is dropped
      if (eof) begin
         if (!was_done && (!word_due || due_word.status == id3fp_pkg::ST_DATA)) begin
            word_due              = 1'b1;
            due_word.status       = id3fp_pkg::ST_TRUNC;
            due_word.picture_byte = 8'h00;
         end
         clear_model();
      end
      if (word_due) begin
         due_word.last = (due_word.status != id3fp_pkg::ST_DATA);
         picture_words.push_back(due_word);
      end
   endfunction

   function automatic void log_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%0t: mismatch: %s", $time, msg);
   endfunction

   function automatic void check_word();
      picture_word_type want;
      words_seen++;
      if (picture_words.size() == 0) begin
         log_fault($sformatf("word %0d unexpected: byte %02h status %0d last %0b",
                             words_seen, rsp.picture_byte, rsp.status, rsp.last));
         return;
      end
      want = picture_words.pop_front();
      if (rsp.picture_byte !== want.picture_byte || rsp.status !== want.status ||
          rsp.last !== want.last)
         log_fault($sformatf({"word %0d: expected byte %02h status %0d last %0b,",
                              " got byte %02h status %0d last %0b"},
                             words_seen, want.picture_byte, want.status, want.last,
                             rsp.picture_byte, rsp.status, rsp.last));
   endfunction

   // Channel monitor
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         picture_words.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_word();
         if (req.valid && req.ready) predict_byte(req.file_byte, req.end_of_file);
      end
      error_count   <= faults;
      words_pending <= picture_words.size();
      bytes_parsed  <= parsed;
   end

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
// ============================================================================
// tb
// Testbench of the ID3v2 first-picture extractor.
// ============================================================================
// Feeds whole files byte by byte: a few hand-built files first, then random
// tags, mostly well formed (extended headers, text frames, picture frames
// with narrow and wide descriptions, padding) with random content, plus
// noise, bad headers, wrong sizes and files cut short. Both channels idle at
// random. The checker predicts and compares every result word.
module tb;

   localparam int unsigned ITEM_TARGET = 1500;
   localparam int unsigned CYCLE_LIMIT = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   id3fp_req_if req_ch ();
   id3fp_rsp_if rsp_ch ();

   int unsigned error_count;
   int unsigned words_pending;
   int unsigned bytes_parsed;
   int unsigned cycle_count = 0;
   logic        quiet = 1'b0;

   logic [7:0] file_q[$];
   logic [7:0] tag_q[$];
   logic [7:0] frame_q[$];

   id3v2_first_picture_extractor_core #(
      .SIZE_BITS(id3fp_pkg::SIZE_BITS_DEFAULT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   id3fp_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .error_count   (error_count),
      .words_pending (words_pending),
      .bytes_parsed  (bytes_parsed)
   );

   // Clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic void put_size(input logic [31:0] v, input logic safe);
      if (safe) begin
         tag_q.push_back({1'b0, v[27:21]});
         tag_q.push_back({1'b0, v[20:14]});
         tag_q.push_back({1'b0, v[13:7]});
         tag_q.push_back({1'b0, v[6:0]});
      end else begin
         tag_q.push_back(v[31:24]);
         tag_q.push_back(v[23:16]);
         tag_q.push_back(v[15:8]);
         tag_q.push_back(v[7:0]);
      end
   endfunction

   // One frame: picture frames with a full layout, or text-like frames
   function automatic void add_frame(input logic v3);
      logic [31:0] id;
      logic [7:0]  enc;
      logic [7:0]  lo;
      logic [7:0]  hi;
      int unsigned r;
      int unsigned size;
      frame_q.delete();
      r = $urandom_range(0, 9);
      if (r < 5) begin
         id  = id3fp_pkg::ID_APIC;
         enc = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         frame_q.push_back(enc);
         repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
         frame_q.push_back(8'h00);
         frame_q.push_back(8'($urandom));
         if (enc == id3fp_pkg::ENC_UTF16 || enc == id3fp_pkg::ENC_UTF16BE) begin
            // pairs may hold single zeros, only an aligned zero pair ends the text
            repeat ($urandom_range(0, 4)) begin
               lo = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
               hi = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
               if (lo == 8'h00 && hi == 8'h00) hi = 8'h20;
               frame_q.push_back(lo);
               frame_q.push_back(hi);
            end
            frame_q.push_back(8'h00);
            frame_q.push_back(8'h00);
         end else begin
            repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(1, 255)));
            frame_q.push_back(8'h00);
         end
         repeat ($urandom_range(0, 12)) frame_q.push_back(8'($urandom));
      end else begin
         if (r == 9) id = $urandom;
         else id = {"T", 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                    8'($urandom_range(48, 90))};
         repeat ($urandom_range(0, 10)) frame_q.push_back(8'($urandom));
      end
      // wrong sizes now and then: zero, overrun, cut layout
      size = frame_q.size();
      r = $urandom_range(0, 11);
      if (r == 0) size = 0;
      else if (r == 1) size = size + $urandom_range(1, 40);
      else if (r == 2 && size > 1) size = size - $urandom_range(1, size - 1);
      tag_q.push_back(id[31:24]);
      tag_q.push_back(id[23:16]);
      tag_q.push_back(id[15:8]);
      tag_q.push_back(id[7:0]);
      put_size(size, !v3);
      if ($urandom_range(0, 7) == 0) begin
         tag_q.push_back(8'($urandom));
         tag_q.push_back(8'($urandom));
      end else begin
         tag_q.push_back(8'h00);
         tag_q.push_back(8'h00);
      end
      foreach (frame_q[i]) tag_q.push_back(frame_q[i]);
   endfunction

   // Random file into file_q
   function automatic void build_file();
      logic [7:0]  ver;
      logic [7:0]  flags;
      int unsigned tag_size;
      int unsigned r;
      int unsigned n;
      tag_q.delete();
      file_q.delete();
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      end else begin
         ver = (r < 10) ? 8'($urandom) : 8'($urandom_range(3, 4));
         n = $urandom_range(0, 9);
         flags = (n == 0) ? 8'($urandom) : ((n < 4) ? 8'h40 : 8'h00);
         // extended header
         if (flags[id3fp_pkg::EXTHDR_BIT]) begin
            if ($urandom_range(0, 9) == 0) begin
               put_size($urandom, 1'b0);
            end else if (ver == id3fp_pkg::VER_3) begin
               n = $urandom_range(0, 6);
               put_size(n, 1'b0);
               repeat (n) tag_q.push_back(8'($urandom));
            end else begin
               n = $urandom_range(0, 10);
               put_size(n, 1'b1);
               if (n > 4) repeat (n - 4) tag_q.push_back(8'($urandom));
            end
         end
         repeat ($urandom_range(0, 4)) add_frame(ver == id3fp_pkg::VER_3);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) tag_q.push_back(8'h00);
         tag_size = tag_q.size();
         r = $urandom_range(0, 9);
         if (r == 0) tag_size = tag_size + $urandom_range(1, 20);
         else if (r == 1 && tag_size > 0)
            tag_size = tag_size - $urandom_range(1, (tag_size > 12) ? 12 : tag_size);
         // tag header
         file_q.push_back(id3fp_pkg::MAGIC_I);
         file_q.push_back(id3fp_pkg::MAGIC_D);
         file_q.push_back(id3fp_pkg::MAGIC_3);
         if ($urandom_range(0, 24) == 0) file_q[$urandom_range(0, 2)] = 8'($urandom);
         file_q.push_back(ver);
         file_q.push_back(8'($urandom));
         file_q.push_back(flags);
         if ($urandom_range(0, 14) == 0) begin
            repeat (4) file_q.push_back(8'($urandom));
         end else begin
            file_q.push_back({1'b0, tag_size[27:21]});
            file_q.push_back({1'b0, tag_size[20:14]});
            file_q.push_back({1'b0, tag_size[13:7]});
            file_q.push_back({1'b0, tag_size[6:0]});
         end
         foreach (tag_q[i]) file_q.push_back(tag_q[i]);
         repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
      end
      // cut short
      if ($urandom_range(0, 4) == 0 && file_q.size() > 1) begin
         n = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > n) void'(file_q.pop_back());
      end
   endfunction

   // Send file_q, end_of_file on its last byte
   task automatic send_file();
      int unsigned gap;
      for (int i = 0; i < file_q.size(); i++) begin
         gap = pick_gap();
         if (gap != 0) begin
            req_ch.valid       <= 1'b0;
            req_ch.file_byte   <= 8'($urandom);
            req_ch.end_of_file <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
         req_ch.valid       <= 1'b1;
         req_ch.file_byte   <= file_q[i];
         req_ch.end_of_file <= (i == file_q.size() - 1);
         do @(posedge clock); while (!req_ch.ready);
      end
   endtask

   // Result side back-pressure
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.file_byte   <= 8'h00;
      req_ch.end_of_file <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bad magic on the first byte
      file_q = '{8'hFF};
      send_file();
      // file ends inside the header
      file_q = '{id3fp_pkg::MAGIC_I, id3fp_pkg::MAGIC_D};
      send_file();
      // unsynchronisation flag set
      file_q = '{id3fp_pkg::MAGIC_I, id3fp_pkg::MAGIC_D, id3fp_pkg::MAGIC_3,
                 id3fp_pkg::VER_4, 8'h00, 8'h80};
      send_file();
      // smallest picture: one APIC frame, one picture byte
      file_q = '{id3fp_pkg::MAGIC_I, id3fp_pkg::MAGIC_D, id3fp_pkg::MAGIC_3,
                 id3fp_pkg::VER_3, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h14,
                 8'h41, 8'h50, 8'h49, 8'h43, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h03, 8'h00, 8'hFF};
      send_file();

      // random files
      while (bytes_parsed < ITEM_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         build_file();
         send_file();
      end
      req_ch.valid <= 1'b0;

      // drain
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
